// ----- rtl/lift_soft_limit_hold_controller_macros.svh -----
// Assertion macros used by the checker file of the lift controller
`ifndef LIFT_SOFT_LIMIT_HOLD_CONTROLLER_MACROS_SVH
`define LIFT_SOFT_LIMIT_HOLD_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is low
`define SLSHC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is low
`define SLSHC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/slshc_pkg.sv -----
// Types, register codes and reset values for the lift soft-limit hold controller
`default_nettype none
package slshc_pkg;

    localparam int POS_W      = 12;
    localparam int MAG_W      = 7;
    localparam int FACTOR_W   = 9;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 3;

    localparam logic [1:0] CMD_MOVE   = 2'd0;
    localparam logic [1:0] CMD_LOCK   = 2'd1;
    localparam logic [1:0] CMD_UNLOCK = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_HEIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_RANGE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_FACTOR = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_BAND   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_POWER  = 3'd6;

    localparam logic [MAG_W-1:0]    RST_MIN_SPEED   = 7'd30;
    localparam logic [POS_W-1:0]    RST_MIN_HEIGHT  = 12'd100;
    localparam logic [POS_W-1:0]    RST_MAX_HEIGHT  = 12'd1500;
    localparam logic [POS_W-1:0]    RST_SLOW_RANGE  = 12'd100;
    localparam logic [FACTOR_W-1:0] RST_SLOW_FACTOR = 9'd205;
    localparam logic [POS_W-1:0]    RST_HOLD_BAND   = 12'd30;
    localparam logic [MAG_W-1:0]    RST_HOLD_POWER  = 7'd50;

    // unity gain in 1/256 units; larger factors clamp here
    localparam logic [FACTOR_W-1:0] FACTOR_UNITY    = 9'd256;

    typedef struct packed {
        logic [MAG_W-1:0]    min_speed;
        logic [POS_W-1:0]    min_height;
        logic [POS_W-1:0]    max_height;
        logic [POS_W-1:0]    slow_range;
        logic [FACTOR_W-1:0] slow_factor;
        logic [POS_W-1:0]    hold_band;
        logic [MAG_W-1:0]    hold_power;
    } slshc_cfg_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [POS_W-1:0]  position;
        logic signed [7:0] speed_request;
        logic              override_hold;
        logic              dampen;
    } slshc_in_t;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              drive_written;
        logic              hold_on;
    } slshc_out_t;

    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] target;
    } slshc_hold_t;

    function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/slshc_cfg_regs.sv -----
// Configuration register bank of the lift controller
`default_nettype none
module slshc_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [slshc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [slshc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output slshc_pkg::slshc_cfg_t                  cfg
);
    import slshc_pkg::*;

    slshc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_speed   <= RST_MIN_SPEED;
            cfg_reg.min_height  <= RST_MIN_HEIGHT;
            cfg_reg.max_height  <= RST_MAX_HEIGHT;
            cfg_reg.slow_range  <= RST_SLOW_RANGE;
            cfg_reg.slow_factor <= RST_SLOW_FACTOR;
            cfg_reg.hold_band   <= RST_HOLD_BAND;
            cfg_reg.hold_power  <= RST_HOLD_POWER;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_SPEED:   cfg_reg.min_speed   <= cfg_wdata[MAG_W-1:0];
                REG_MIN_HEIGHT:  cfg_reg.min_height  <= cfg_wdata[POS_W-1:0];
                REG_MAX_HEIGHT:  cfg_reg.max_height  <= cfg_wdata[POS_W-1:0];
                REG_SLOW_RANGE:  cfg_reg.slow_range  <= cfg_wdata[POS_W-1:0];
                REG_SLOW_FACTOR: cfg_reg.slow_factor <= cfg_wdata[FACTOR_W-1:0];
                REG_HOLD_BAND:   cfg_reg.hold_band   <= cfg_wdata[POS_W-1:0];
                REG_HOLD_POWER:  cfg_reg.hold_power  <= cfg_wdata[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- rtl/slshc_step.sv -----
// Per-command logic: deadband, soft-limit slowdown and cut-off, hold correction
`default_nettype none
module slshc_step (
    input  wire slshc_pkg::slshc_in_t   item,
    input  wire slshc_pkg::slshc_cfg_t  cfg,
    input  wire slshc_pkg::slshc_hold_t hold_reg,
    output slshc_pkg::slshc_out_t       result,
    output slshc_pkg::slshc_hold_t      hold_next
);
    import slshc_pkg::*;

    logic signed [7:0]   speed_sat;
    logic [7:0]          speed_neg;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    mag_db;
    logic                up;
    logic [POS_W-1:0]    limit;
    logic                near;
    logic                beyond;
    logic [FACTOR_W-1:0] factor;
    logic [15:0]         prod;
    logic [MAG_W-1:0]    mag_out;
    logic [7:0]          move_drive;
    logic                outside;
    logic [7:0]          tick_drive;

    always_comb begin
        // most negative request clamps to -127
        speed_sat = (item.speed_request == 8'sh80) ? -8'sd127 : item.speed_request;
        neg       = speed_sat[7];
        speed_neg = -speed_sat;
        mag       = neg ? speed_neg[MAG_W-1:0] : speed_sat[MAG_W-1:0];
        mag_db    = (mag < cfg.min_speed) ? '0 : mag;

        // zero speed takes the lower-limit path
        up     = !neg && (mag_db != '0);
        limit  = up ? cfg.max_height : cfg.min_height;
        near   = item.dampen && (absdiff(limit, item.position) < cfg.slow_range);
        beyond = up ? (item.position > cfg.max_height) : (item.position < cfg.min_height);

        factor  = (cfg.slow_factor > FACTOR_UNITY) ? FACTOR_UNITY : cfg.slow_factor;
        prod    = {9'd0, mag_db} * {7'd0, factor};
        // 127 * 256 stays below 2^15, so bits 14:8 hold the whole product >> 8
        mag_out = beyond ? '0 : (near ? prod[14:8] : mag_db);
        move_drive = neg ? -{1'b0, mag_out} : {1'b0, mag_out};

        outside    = absdiff(item.position, hold_reg.target) > cfg.hold_band;
        tick_drive = !outside ? 8'd0 :
                     (item.position < hold_reg.target) ? {1'b0, cfg.hold_power}
                                                       : -{1'b0, cfg.hold_power};

        hold_next            = hold_reg;
        result.drive         = '0;
        result.drive_written = 1'b0;

        case (item.command)
            CMD_MOVE: begin
                if (!hold_reg.active || item.override_hold) begin
                    hold_next.active     = 1'b0;
                    result.drive         = move_drive;
                    result.drive_written = 1'b1;
                end
            end
            CMD_LOCK: begin
                if (!hold_reg.active) begin
                    hold_next.active = 1'b1;
                    hold_next.target = item.position;
                end
            end
            CMD_UNLOCK: begin
                hold_next.active = 1'b0;
            end
            CMD_TICK: begin
                if (hold_reg.active) begin
                    result.drive         = tick_drive;
                    result.drive_written = 1'b1;
                end
            end
            default: begin
            end
        endcase

        result.hold_on = hold_next.active;
    end

endmodule
`default_nettype wire

// ----- rtl/lift_soft_limit_hold_controller.sv -----
// Top level of the lift soft-limit hold controller
//
// One result word per command word. A word is taken into the input register,
// worked through the combinational command logic and written to the result
// register together with the new hold state, and the block sustains one word
// per cycle whenever the result side keeps up. The input side stays ready
// while a finished result waits, as long as the input register is free or
// moving on. Configuration writes take effect in the cycle after cfg_we and
// should only be issued while no word is in flight.
`default_nettype none
module lift_soft_limit_hold_controller (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire slshc_pkg::slshc_in_t             s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output slshc_pkg::slshc_out_t                 m_data,
    input  wire logic                             cfg_we,
    input  wire logic [slshc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [slshc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import slshc_pkg::*;

    slshc_cfg_t  cfg;
    slshc_in_t   in_data_reg;
    logic        in_valid_reg;
    slshc_out_t  out_data_reg;
    logic        out_valid_reg;
    slshc_hold_t hold_reg;
    slshc_hold_t hold_next;
    slshc_out_t  result;
    logic        advance;

    slshc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slshc_step u_step (
        .item      (in_data_reg),
        .cfg       (cfg),
        .hold_reg  (hold_reg),
        .result    (result),
        .hold_next (hold_next)
    );

    // word moves to the result register when that register is empty or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                hold_reg      <= hold_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/slshc_checker.sv -----
// Port-level checks for the lift controller and their binding to the top level
`default_nettype none
`include "lift_soft_limit_hold_controller_macros.svh"
module slshc_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire slshc_pkg::slshc_out_t m_data
);
    import slshc_pkg::*;

    `SLSHC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
                       m_valid && $stable(m_data), "result word changed while stalled")
    `SLSHC_ASSERT_NOW(a_idle_drive, m_valid && !m_data.drive_written,
                      m_data.drive == 8'sd0, "drive not zero on a word that leaves the motors")
    `SLSHC_ASSERT_NOW(a_drive_range, m_valid,
                      m_data.drive != 8'sh80, "drive outside the symmetric range")

endmodule

bind lift_soft_limit_hold_controller slshc_checker u_slshc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ----- verif/tb_lift_soft_limit_hold_controller.sv -----
// Self-checking testbench for the lift soft-limit hold controller
module tb_lift_soft_limit_hold_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import slshc_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    slshc_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    slshc_out_t            m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lift_soft_limit_hold_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // predictor copy of the registers and hold state
    int lim_min_speed   = RST_MIN_SPEED;
    int lim_min_height  = RST_MIN_HEIGHT;
    int lim_max_height  = RST_MAX_HEIGHT;
    int lim_slow_range  = RST_SLOW_RANGE;
    int lim_slow_factor = RST_SLOW_FACTOR;
    int lim_hold_band   = RST_HOLD_BAND;
    int lim_hold_power  = RST_HOLD_POWER;
    bit held            = 1'b0;
    int held_target     = 0;

    slshc_out_t pending_results[$];
    int         n_faults      = 0;
    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;

    function automatic int pos_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // scale by slow_factor/256, truncating toward zero
    function automatic int damp_scale(int s);
        int f;
        int mag;
        f   = (lim_slow_factor > int'(FACTOR_UNITY)) ? int'(FACTOR_UNITY) : lim_slow_factor;
        mag = (s < 0) ? -s : s;
        mag = (mag * f) / 256;
        return (s < 0) ? -mag : mag;
    endfunction

    function automatic slshc_out_t lift_response(slshc_in_t w);
        slshc_out_t r;
        int spd;
        int pos;
        int drv;
        bit wr;
        spd = w.speed_request;
        pos = w.position;
        drv = 0;
        wr  = 1'b0;
        if (spd < -127)
            spd = -127;
        case (w.command)
            CMD_MOVE: begin
                if (((spd < 0) ? -spd : spd) < lim_min_speed)
                    spd = 0;
                if (!held || w.override_hold) begin
                    held = 1'b0;
                    if (spd > 0) begin
                        if (w.dampen && pos_gap(lim_max_height, pos) < lim_slow_range)
                            spd = damp_scale(spd);
                        if (pos > lim_max_height)
                            spd = 0;
                    end else begin
                        // zero speed takes the downward path
                        if (w.dampen && pos_gap(lim_min_height, pos) < lim_slow_range)
                            spd = damp_scale(spd);
                        if (pos < lim_min_height)
                            spd = 0;
                    end
                    drv = spd;
                    wr  = 1'b1;
                end
            end
            CMD_LOCK: begin
                if (!held) begin
                    held        = 1'b1;
                    held_target = pos;
                end
            end
            CMD_UNLOCK: held = 1'b0;
            default: begin
                if (held) begin
                    if (pos_gap(pos, held_target) > lim_hold_band)
                        drv = (pos < held_target) ? lim_hold_power : -lim_hold_power;
                    wr = 1'b1;
                end
            end
        endcase
        r.drive         = drv[7:0];
        r.drive_written = wr;
        r.hold_on       = held;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        slshc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                n_faults++;
                if (n_faults <= 100)
                    $display("%0t: unexpected word, expected none, got drive %0d written %0b hold %0b",
                             $time, m_data.drive, m_data.drive_written, m_data.hold_on);
            end else begin
                want = pending_results.pop_front();
                if (m_data.drive !== want.drive || m_data.drive_written !== want.drive_written
                        || m_data.hold_on !== want.hold_on) begin
                    n_faults++;
                    if (n_faults <= 100)
                        $display("%0t: mismatch, expected drive %0d written %0b hold %0b, got drive %0d written %0b hold %0b",
                                 $time, want.drive, want.drive_written, want.hold_on,
                                 m_data.drive, m_data.drive_written, m_data.hold_on);
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic send_word(input slshc_in_t w);
        @(negedge aclk);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lift_response(w));
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MIN_SPEED:   lim_min_speed   = val & 'h7F;
            REG_MIN_HEIGHT:  lim_min_height  = val & 'hFFF;
            REG_MAX_HEIGHT:  lim_max_height  = val & 'hFFF;
            REG_SLOW_RANGE:  lim_slow_range  = val & 'hFFF;
            REG_SLOW_FACTOR: lim_slow_factor = val & 'h1FF;
            REG_HOLD_BAND:   lim_hold_band   = val & 'hFFF;
            REG_HOLD_POWER:  lim_hold_power  = val & 'h7F;
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input int v);
        write_reg(REG_MIN_SPEED, v);
        write_reg(REG_MIN_HEIGHT, v);
        write_reg(REG_MAX_HEIGHT, v);
        write_reg(REG_SLOW_RANGE, v);
        write_reg(REG_SLOW_FACTOR, v);
        write_reg(REG_HOLD_BAND, v);
        write_reg(REG_HOLD_POWER, v);
    endtask

    task automatic shuffle_config();
        int lo;
        lo = $urandom_range(1500);
        write_reg(REG_MIN_SPEED, $urandom_range(127));
        write_reg(REG_MIN_HEIGHT, lo);
        write_reg(REG_MAX_HEIGHT,
                  ($urandom_range(3) == 0) ? $urandom_range(4095) : lo + $urandom_range(2500));
        write_reg(REG_SLOW_RANGE, $urandom_range(400));
        write_reg(REG_SLOW_FACTOR, $urandom_range(511));
        write_reg(REG_HOLD_BAND, $urandom_range(150));
        write_reg(REG_HOLD_POWER, $urandom_range(127));
    endtask

    function automatic slshc_in_t word_of(logic [1:0] c, int p, int s, bit ovr, bit dmp);
        slshc_in_t w;
        w.command       = c;
        w.position      = p[POS_W-1:0];
        w.speed_request = s[7:0];
        w.override_hold = ovr;
        w.dampen        = dmp;
        return w;
    endfunction

    // positions cluster round the soft limits and the hold target
    function automatic int pick_position();
        int sel;
        int base;
        int span;
        int p;
        sel = $urandom_range(4);
        case (sel)
            0: base = lim_min_height;
            1: base = lim_max_height;
            2: base = held_target;
            default: return $urandom_range(4095);
        endcase
        span = ((sel == 2) ? lim_hold_band : lim_slow_range) + 3;
        p = base + $urandom_range(2 * span) - span;
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        return p;
    endfunction

    function automatic slshc_in_t random_word();
        int r;
        int m;
        int s;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0, 1: s = $urandom_range(255);
            2: begin
                m = lim_min_speed + $urandom_range(4) - 2;
                if (m < 0)
                    m = 0;
                if (m > 127)
                    m = 127;
                s = $urandom_range(1) ? m : -m;
            end
            default: begin
                case ($urandom_range(4))
                    0: s = -128;
                    1: s = -127;
                    2: s = 127;
                    3: s = 0;
                    default: s = $urandom_range(1) ? 1 : -1;
                endcase
            end
        endcase
        return word_of((r < 48) ? CMD_MOVE : (r < 63) ? CMD_LOCK : (r < 73) ? CMD_UNLOCK : CMD_TICK,
                       pick_position(), s, $urandom_range(1), $urandom_range(9) < 7);
    endfunction

    task automatic run_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(199) == 0)
                drain();
            send_word(random_word());
        end
    endtask

    // reset register values, every command and the corner cases
    task automatic test_directed_defaults();
        send_word(word_of(CMD_TICK,   800,   50, 0, 0)); // tick with no hold
        send_word(word_of(CMD_UNLOCK, 800,    0, 0, 0)); // unlock while free
        send_word(word_of(CMD_MOVE,   800,  127, 0, 1));
        send_word(word_of(CMD_MOVE,   800, -128, 0, 1)); // saturates
        send_word(word_of(CMD_MOVE,   800,   29, 0, 0)); // below min speed
        send_word(word_of(CMD_MOVE,   800,  -30, 0, 0));
        send_word(word_of(CMD_MOVE,   800,    0, 1, 1));
        send_word(word_of(CMD_MOVE,  1450,  100, 0, 1)); // slow zone up
        send_word(word_of(CMD_MOVE,  1450,  100, 0, 0));
        send_word(word_of(CMD_MOVE,  1501,  100, 0, 1)); // past upper limit
        send_word(word_of(CMD_MOVE,  4095, -100, 0, 1));
        send_word(word_of(CMD_MOVE,   150, -127, 0, 1)); // slow zone down
        send_word(word_of(CMD_MOVE,     0,  -50, 0, 0)); // below lower limit
        send_word(word_of(CMD_MOVE,     0,   50, 0, 1));
        send_word(word_of(CMD_LOCK,  1000,    0, 0, 0));
        send_word(word_of(CMD_LOCK,  2000,    0, 0, 0)); // target kept
        send_word(word_of(CMD_TICK,  1030,    0, 0, 0)); // on band edge
        send_word(word_of(CMD_TICK,  1031,    0, 0, 0));
        send_word(word_of(CMD_TICK,   969,    0, 0, 0));
        send_word(word_of(CMD_MOVE,  1000,   80, 0, 0)); // blocked by hold
        send_word(word_of(CMD_MOVE,  1000,   80, 1, 0)); // override releases
        send_word(word_of(CMD_TICK,  1000,    0, 0, 0));
        send_word(word_of(CMD_LOCK,  4095,   -1, 1, 1));
        send_word(word_of(CMD_UNLOCK,   0,  127, 1, 1));
        send_word(word_of(CMD_MOVE,  2000,   -1, 0, 0));
        drain();
    endtask

    task automatic test_register_extremes();
        set_all_regs(0);
        run_traffic(60);
        drain();
        set_all_regs('hFFF);
        run_traffic(60);
        drain();
    endtask

    // a factor of zero, exact unity and an out-of-range value that clamps
    task automatic test_slow_factor_edges();
        set_all_regs(0);
        write_reg(REG_MIN_HEIGHT, RST_MIN_HEIGHT);
        write_reg(REG_MAX_HEIGHT, RST_MAX_HEIGHT);
        write_reg(REG_SLOW_RANGE, 400);
        write_reg(REG_HOLD_POWER, RST_HOLD_POWER);
        write_reg(REG_SLOW_FACTOR, 0);
        run_traffic(30);
        drain();
        write_reg(REG_SLOW_FACTOR, FACTOR_UNITY);
        run_traffic(30);
        drain();
        write_reg(REG_SLOW_FACTOR, 'h1FF);
        run_traffic(30);
        drain();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int k = 0; k < 3; k++) begin
            shuffle_config();
            run_traffic(95);
            drain();
        end
    endtask

    initial begin
        src_idle_pct  = 20;
        sink_idle_pct = 58;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_directed_defaults();
        test_register_extremes();
        test_slow_factor_edges();
        test_random_traffic(20, 58);
        test_random_traffic(58, 20);
        test_random_traffic(0, 0);
        drain();
        repeat (10) @(posedge aclk);
        if (n_faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/slshc_pkg.sv
rtl/slshc_cfg_regs.sv
rtl/slshc_step.sv
rtl/lift_soft_limit_hold_controller.sv
rtl/slshc_checker.sv
verif/tb_lift_soft_limit_hold_controller.sv
